>>> sv/biou_pkg.sv
// shared types and constants for the box intersection-over-union block
package biou_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int AREA_OUT_BITS = 32;

  typedef struct packed {
    logic full;
    logic empty;
  } biou_fifo_stat_t;

endpackage

>>> sv/biou_if.sv
// valid/ready channel interfaces for box pairs and iou results
interface biou_in_if #(parameter int COORD_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] a_left;
  logic [COORD_BITS-1:0] a_top;
  logic [COORD_BITS-1:0] a_right;
  logic [COORD_BITS-1:0] a_bottom;
  logic [COORD_BITS-1:0] b_left;
  logic [COORD_BITS-1:0] b_top;
  logic [COORD_BITS-1:0] b_right;
  logic [COORD_BITS-1:0] b_bottom;

  modport source (
    output valid, a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom,
    input  ready
  );
  modport sink (
    input  valid, a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom,
    output ready
  );
endinterface

interface biou_out_if #(parameter int RATIO_FRAC_BITS = 16);
  logic                     valid;
  logic                     ready;
  logic [RATIO_FRAC_BITS:0] ratio;
  logic [31:0]              overlap_area;
  logic                     invalid;

  modport source (output valid, ratio, overlap_area, invalid, input ready);
  modport sink   (input valid, ratio, overlap_area, invalid, output ready);
endinterface

>>> sv/biou_front.sv
// front pipeline: overlap lengths, areas, union and validity of a box pair
module biou_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  biou_in_if.sink                     in_ch,
  input  biou_pkg::biou_fifo_stat_t   q_stat,
  output logic                        push,
  output logic [4*COORD_BITS+1:0]     push_data
);
  import biou_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int AW = 2 * COORD_BITS;

  logic          fe;
  logic          in_acc;

  // stage 1: lengths
  logic          s1_vld_r;
  logic          s1_rev_r;
  logic [CW-1:0] s1_wa_r, s1_ha_r, s1_wb_r, s1_hb_r, s1_ow_r, s1_oh_r;
  logic [CW-1:0] lo_x, hi_x, lo_y, hi_y, ow, oh;
  logic          rev;

  // stage 2: products
  logic          s2_vld_r;
  logic          s2_rev_r;
  logic [AW-1:0] s2_area_a_r, s2_area_b_r, s2_inter_r;

  // stage 3: union
  logic          s3_vld_r;
  logic          s3_inv_r;
  logic [AW-1:0] s3_inter_r;
  logic [AW:0]   s3_uni_r;
  logic [AW:0]   uni;

  assign fe       = !s3_vld_r || !q_stat.full;
  assign in_ch.ready = fe;
  assign in_acc   = in_ch.valid && fe;

  always_comb begin
    lo_x = (in_ch.a_left > in_ch.b_left) ? in_ch.a_left : in_ch.b_left;
    hi_x = (in_ch.a_right < in_ch.b_right) ? in_ch.a_right : in_ch.b_right;
    lo_y = (in_ch.a_top > in_ch.b_top) ? in_ch.a_top : in_ch.b_top;
    hi_y = (in_ch.a_bottom < in_ch.b_bottom) ? in_ch.a_bottom : in_ch.b_bottom;
    ow   = (hi_x > lo_x) ? hi_x - lo_x : '0;
    oh   = (hi_y > lo_y) ? hi_y - lo_y : '0;
    rev  = (in_ch.a_right < in_ch.a_left) || (in_ch.a_bottom < in_ch.a_top) ||
           (in_ch.b_right < in_ch.b_left) || (in_ch.b_bottom < in_ch.b_top);
  end

  // area sum less intersection; intersection never exceeds either area
  assign uni = ({1'b0, s2_area_a_r} + {1'b0, s2_area_b_r}) - {1'b0, s2_inter_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (fe) begin
      s1_vld_r <= in_acc;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      s1_rev_r    <= rev;
      s1_wa_r     <= in_ch.a_right - in_ch.a_left;
      s1_ha_r     <= in_ch.a_bottom - in_ch.a_top;
      s1_wb_r     <= in_ch.b_right - in_ch.b_left;
      s1_hb_r     <= in_ch.b_bottom - in_ch.b_top;
      s1_ow_r     <= ow;
      s1_oh_r     <= oh;

      s2_rev_r    <= s1_rev_r;
      s2_area_a_r <= AW'(s1_wa_r) * AW'(s1_ha_r);
      s2_area_b_r <= AW'(s1_wb_r) * AW'(s1_hb_r);
      s2_inter_r  <= AW'(s1_ow_r) * AW'(s1_oh_r);

      s3_inv_r    <= s2_rev_r || (uni == '0);
      s3_inter_r  <= s2_inter_r;
      s3_uni_r    <= uni;
    end
  end

  assign push      = s3_vld_r && !q_stat.full;
  assign push_data = {s3_inv_r, s3_uni_r, s3_inter_r};

endmodule

>>> sv/biou_fifo.sv
// short queue that decouples the front pipeline from the divider
module biou_fifo #(
  parameter int WIDTH = 66
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic [WIDTH-1:0]          push_data,
  input  logic                      pop,
  output logic [WIDTH-1:0]          head_data,
  output biou_pkg::biou_fifo_stat_t stat
);
  import biou_pkg::*;

  logic [WIDTH-1:0]      mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign stat.full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/biou_back.sv
// back pipeline: one quotient bit per stage, restoring division of intersection by union
module biou_back #(
  parameter int COORD_BITS      = 16,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  biou_pkg::biou_fifo_stat_t q_stat,
  input  logic [4*COORD_BITS+1:0]   head_data,
  output logic                      pop,
  biou_out_if.source                out_ch
);
  import biou_pkg::*;

  localparam int AW = 2 * COORD_BITS;
  localparam int DW = AW + 1;
  localparam int RW = AW + 2;
  localparam int QW = RATIO_FRAC_BITS + 1;
  localparam int NS = RATIO_FRAC_BITS + 1;

  logic          be;
  logic          vld_r   [NS];
  logic          inv_r   [NS];
  logic [AW-1:0] inter_r [NS];
  logic [DW-1:0] den_r   [NS];
  logic [RW-1:0] rem_r   [NS];
  logic [QW-1:0] q_r     [NS];

  logic          h_inv;
  logic [DW-1:0] h_uni;
  logic [AW-1:0] h_inter;
  logic [RW-1:0] r0;
  logic          ge0;
  logic          sat;

  assign be  = !vld_r[NS-1] || out_ch.ready;
  assign pop = be && !q_stat.empty;

  assign {h_inv, h_uni, h_inter} = head_data;
  assign r0  = RW'(h_inter);
  assign ge0 = (r0 >= RW'(h_uni));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (be) begin
      vld_r[0] <= !q_stat.empty;
    end
  end

  // integer bit: set only when intersection equals union
  always_ff @(posedge clk) begin
    if (be) begin
      inv_r[0]   <= h_inv;
      inter_r[0] <= h_inter;
      den_r[0]   <= h_uni;
      rem_r[0]   <= ge0 ? r0 - RW'(h_uni) : r0;
      q_r[0]     <= QW'(ge0);
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_stage
    logic [RW-1:0] rs;
    logic          ge;

    assign rs = {rem_r[k-1][RW-2:0], 1'b0};
    assign ge = (rs >= RW'(den_r[k-1]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (be) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (be) begin
        inv_r[k]   <= inv_r[k-1];
        inter_r[k] <= inter_r[k-1];
        den_r[k]   <= den_r[k-1];
        rem_r[k]   <= ge ? rs - RW'(den_r[k-1]) : rs;
        q_r[k]     <= {q_r[k-1][QW-2:0], ge};
      end
    end
  end

  // saturation only possible when the area is wider than the output field
  assign sat = (AW > AREA_OUT_BITS) ?
               (inter_r[NS-1] > AW'({AREA_OUT_BITS{1'b1}})) : 1'b0;

  assign out_ch.valid        = vld_r[NS-1];
  assign out_ch.invalid      = inv_r[NS-1];
  assign out_ch.ratio        = inv_r[NS-1] ? '0 : q_r[NS-1];
  assign out_ch.overlap_area = inv_r[NS-1] ? '0 :
                               sat ? '1 : AREA_OUT_BITS'(inter_r[NS-1]);

endmodule

>>> sv/box_iou.sv
// top level of the box intersection-over-union block
// Takes one pair of axis-aligned boxes per transaction (unsigned corner coordinates
// with 4 fraction bits) and returns the intersection-over-union ratio with
// RATIO_FRAC_BITS fraction bits (1 << RATIO_FRAC_BITS means 1.0), the intersection
// area with 8 fraction bits, and an invalid flag for a reversed box or an empty union.
// A new pair is taken every cycle unless the front pipeline is held by a full queue.
// Each pair passes through 3 front stages, the queue and RATIO_FRAC_BITS + 1 divider
// stages, one quotient bit each. A 4-entry queue sits between the area pipeline and
// the divider, so each side stalls independently.
module box_iou #(
  parameter int COORD_BITS      = 16,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  biou_in_if.sink     in_ch,
  biou_out_if.source  out_ch
);
  import biou_pkg::*;

  localparam int EW = 4 * COORD_BITS + 2;

  logic            push;
  logic            pop;
  logic [EW-1:0]   push_data;
  logic [EW-1:0]   head_data;
  biou_fifo_stat_t q_stat;

  biou_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  biou_fifo #(
    .WIDTH (EW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .stat      (q_stat)
  );

  biou_back #(
    .COORD_BITS      (COORD_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_data (head_data),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
